[hw/rtl/ring_buffer_deque_defines.svh]
// Assertion macros for the ring buffer deque.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// same-cycle implication, off during reset
`define RBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rbd_pkg.sv]
// Shared types and constants for the ring buffer deque.
// No dependencies.
package rbd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 3;
    localparam int POS_W      = 4;
    localparam int STAT_W     = 2;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ_INDEX = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [PTR_W-1:0]      addr;
        logic [DATA_WIDTH-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_out;
        logic [CNT_W-1:0]      count_after;
        t_status               status;
    } t_rsp;

endpackage

[hw/rtl/rbd_ifs.sv]
// Request and response channel interfaces of the ring buffer deque.
// Depends on rbd_pkg.
interface rbd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [rbd_pkg::CMD_W-1:0]      cmd;
    logic [rbd_pkg::DATA_WIDTH-1:0] push_value;
    logic [rbd_pkg::POS_W-1:0]      position;

    modport source (output valid, cmd, push_value, position, input ready);
    modport sink   (input valid, cmd, push_value, position, output ready);
endinterface

interface rbd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rbd_pkg::DATA_WIDTH-1:0] data_out;
    logic [rbd_pkg::CNT_W-1:0]      count_after;
    logic [rbd_pkg::STAT_W-1:0]     status;

    modport source (output valid, data_out, count_after, status, input ready);
    modport sink   (input valid, data_out, count_after, status, output ready);
endinterface

[hw/rtl/rbd_ram.sv]
// Generic single-port synchronous RAM, registered read data, read-first.
// No dependencies.
module rbd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rbd_ctrl.sv]
// Pointer, count and sequencing control of the ring buffer deque.
// Depends on rbd_pkg and rbd_cmd_if; drives the RAM request and result loads.
module rbd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rbd_cmd_if.sink                       i_cmd,
    input  logic                          i_slot_free,
    input  logic [rbd_pkg::DATA_WIDTH-1:0] i_rdata,
    output rbd_pkg::t_mem_req             o_mem_req,
    output logic                          o_load,
    output rbd_pkg::t_rsp                 o_rsp
);

    rbd_pkg::t_state                r_state, n_state;
    logic [rbd_pkg::PTR_W-1:0]      r_front, n_front;
    logic [rbd_pkg::PTR_W-1:0]      r_back, n_back;
    logic [rbd_pkg::CNT_W-1:0]      r_count, n_count;

    logic                           accept;
    logic                           full;
    logic                           empty;
    logic                           in_range;
    rbd_pkg::t_status               status;

    assign i_cmd.ready = (r_state == rbd_pkg::S_IDLE) && i_slot_free;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign full        = (r_count == rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
    assign empty       = (r_count == '0);
    assign in_range    = (rbd_pkg::CMP_W'(i_cmd.position) < rbd_pkg::CMP_W'(r_count));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbd_pkg::S_IDLE: begin
                if (accept && o_mem_req.re) begin
                    n_state = rbd_pkg::S_READ;
                end
            end
            rbd_pkg::S_READ: begin
                n_state = rbd_pkg::S_IDLE;
            end
            default: begin
                n_state = rbd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_front         = r_front;
        n_back          = r_back;
        n_count         = r_count;
        status          = rbd_pkg::ST_OK;
        o_mem_req.we    = 1'b0;
        o_mem_req.re    = 1'b0;
        o_mem_req.addr  = r_front;
        o_mem_req.wdata = i_cmd.push_value;
        if (r_state == rbd_pkg::S_IDLE) begin
            unique case (rbd_pkg::t_cmd'(i_cmd.cmd))
                rbd_pkg::CMD_PUSH_BACK: begin
                    if (full) begin
                        status = rbd_pkg::ST_FULL;
                    end else begin
                        o_mem_req.we   = accept;
                        o_mem_req.addr = r_back;
                        n_back         = r_back + rbd_pkg::PTR_W'(1);
                        n_count        = r_count + rbd_pkg::CNT_W'(1);
                    end
                end
                rbd_pkg::CMD_PUSH_FRONT: begin
                    if (full) begin
                        status = rbd_pkg::ST_FULL;
                    end else begin
                        o_mem_req.we   = accept;
                        o_mem_req.addr = r_front - rbd_pkg::PTR_W'(1);
                        n_front        = r_front - rbd_pkg::PTR_W'(1);
                        n_count        = r_count + rbd_pkg::CNT_W'(1);
                    end
                end
                rbd_pkg::CMD_POP_BACK: begin
                    if (empty) begin
                        status = rbd_pkg::ST_EMPTY;
                    end else begin
                        o_mem_req.re   = 1'b1;
                        o_mem_req.addr = r_back - rbd_pkg::PTR_W'(1);
                        n_back         = r_back - rbd_pkg::PTR_W'(1);
                        n_count        = r_count - rbd_pkg::CNT_W'(1);
                    end
                end
                rbd_pkg::CMD_POP_FRONT: begin
                    if (empty) begin
                        status = rbd_pkg::ST_EMPTY;
                    end else begin
                        o_mem_req.re   = 1'b1;
                        o_mem_req.addr = r_front;
                        n_front        = r_front + rbd_pkg::PTR_W'(1);
                        n_count        = r_count - rbd_pkg::CNT_W'(1);
                    end
                end
                rbd_pkg::CMD_READ_INDEX: begin
                    if (!in_range) begin
                        status = rbd_pkg::ST_RANGE;
                    end else begin
                        o_mem_req.re   = 1'b1;
                        o_mem_req.addr = r_front + rbd_pkg::PTR_W'(i_cmd.position);
                    end
                end
                rbd_pkg::CMD_CLEAR: begin
                    n_front = '0;
                    n_back  = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end

        if (r_state == rbd_pkg::S_READ) begin
            o_load            = 1'b1;
            o_rsp.data_out    = i_rdata;
            o_rsp.count_after = r_count;
            o_rsp.status      = rbd_pkg::ST_OK;
        end else begin
            o_load            = accept && !o_mem_req.re;
            o_rsp.data_out    = '0;
            o_rsp.count_after = n_count;
            o_rsp.status      = status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbd_pkg::S_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
            end
        end
    end

endmodule

[hw/rtl/rbd_out.sv]
// Output register of the ring buffer deque response channel.
// Depends on rbd_pkg and rbd_rsp_if.
module rbd_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  rbd_pkg::t_rsp i_rsp,
    output logic          o_slot_free,
    rbd_rsp_if.source     o_rsp
);

    logic          r_valid;
    rbd_pkg::t_rsp r_rsp;

    assign o_slot_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.data_out    = r_rsp.data_out;
    assign o_rsp.count_after = r_rsp.count_after;
    assign o_rsp.status      = r_rsp.status;

endmodule

[hw/rtl/ring_buffer_deque.sv]
// Channel   Dir  Handshake     Payload
// i_cmd     in   valid/ready   cmd, push_value, position
// o_rsp     out  valid/ready   data_out, count_after, status
//
// Push, clear, refused and unused requests load the output register when taken; pops
// and index reads first pass through S_READ, which loads the registered element RAM data.
// The request side stalls while a read is in flight or a full output register is not drained.
// Reset is synchronous, active low; it clears pointers, count and the output valid.
// Element RAM has no reset; only written entries are ever read.
`include "ring_buffer_deque_defines.svh"
module ring_buffer_deque (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbd_cmd_if.sink   i_cmd,
    rbd_rsp_if.source o_rsp
);

    rbd_pkg::t_mem_req              mem_req;
    rbd_pkg::t_rsp                  rsp;
    logic                           load;
    logic                           slot_free;
    logic [rbd_pkg::DATA_WIDTH-1:0] rdata;

    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_slot_free (slot_free),
        .i_rdata     (rdata),
        .o_mem_req   (mem_req),
        .o_load      (load),
        .o_rsp       (rsp)
    );

    rbd_ram #(
        .DEPTH (rbd_pkg::DEPTH),
        .WIDTH (rbd_pkg::DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (rdata)
    );

    rbd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_rsp       (rsp),
        .o_slot_free (slot_free),
        .o_rsp       (o_rsp)
    );

    `RBD_ASSERT_NEXT(a_read_interlock, mem_req.re && i_cmd.valid && i_cmd.ready, !i_cmd.ready, "request taken while read in flight")
    `RBD_ASSERT_NOW(a_full_resp, o_rsp.valid && (o_rsp.status == rbd_pkg::ST_FULL), (o_rsp.data_out == '0) && (o_rsp.count_after == rbd_pkg::CNT_W'(rbd_pkg::DEPTH)), "bad refused push response")
    `RBD_ASSERT_NOW(a_empty_resp, o_rsp.valid && (o_rsp.status == rbd_pkg::ST_EMPTY), (o_rsp.data_out == '0) && (o_rsp.count_after == '0), "bad refused pop response")

endmodule
